// ===== rtl/perspective_world_to_screen_top_defines.svh =====
// Assertion macros shared by the RTL of the projection block.
`ifndef PERSPECTIVE_WORLD_TO_SCREEN_TOP_DEFINES_SVH
`define PERSPECTIVE_WORLD_TO_SCREEN_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define PWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define PWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pws_pkg
// Types and constants of the perspective projection block.
// ----------------------------------------------------------------------------
package pws_pkg;

  localparam int unsigned CfgWidth = 14;
  localparam int unsigned CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] CFG_SCREEN_WIDTH = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CFG_SCREEN_HEIGHT = 1'b1;
  localparam logic [CfgWidth-1:0] WidthReset = 14'd1024;
  localparam logic [CfgWidth-1:0] HeightReset = 14'd768;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_XFORM = 1'b1;

  localparam int unsigned ClipWidth = 50;
  localparam logic signed [ClipWidth-1:0] WMinRaw = 50'sd6554;

  // Quotient: magnitude of numerator up to 2^49, shifted by 16.
  localparam int unsigned NumWidth = 66;
  localparam int unsigned DivSteps = 66;

  typedef struct packed {
    logic               action;
    logic [3:0]         word_index;
    logic signed [31:0] word_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic               in_front;
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
  } out_word_t;

  // Classified transform job passed from front to back.
  typedef struct packed {
    logic                       in_front;
    logic signed [ClipWidth-1:0] cx;
    logic signed [ClipWidth-1:0] cy;
    logic signed [ClipWidth-1:0] cw;
  } job_t;

endpackage

// ===== rtl/pws_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pws_front
// Holds the matrix, forms the clip components in a pipeline.
// ----------------------------------------------------------------------------
module pws_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  pws_pkg::in_word_t in_word_i,
  input  logic              stall_i,
  output logic              job_valid_o,
  output pws_pkg::job_t     job_o,
  output logic              busy_o
);

  localparam int unsigned ClipSumW = pws_pkg::ClipWidth;
  localparam int Rows [3] = '{0, 1, 3};

  logic signed [31:0] mat_q [16];
  logic               s1_valid_q, s2_valid_q;
  // Stage 1: nine products, rescaled with floor.
  logic signed [47:0] prod_q [3][3];
  logic signed [31:0] tr_q [3];
  logic signed [63:0] prod_full [3][3];
  logic signed [31:0] pt [3];
  logic signed [ClipSumW-1:0] sum [3];
  pws_pkg::job_t job_q;

  assign pt[0] = in_word_i.point_x;
  assign pt[1] = in_word_i.point_y;
  assign pt[2] = in_word_i.point_z;

  wire xform = in_valid_i && (in_word_i.action == pws_pkg::ACT_XFORM);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_full[r][k] = 64'(pt[k]) * 64'(mat_q[4*k + Rows[r]]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) mat_q[i] <= '0;
    end else if (in_valid_i && in_word_i.action == pws_pkg::ACT_LOAD) begin
      mat_q[in_word_i.word_index] <= in_word_i.word_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (!stall_i) begin
      s1_valid_q <= xform;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Arithmetic shift right is floor division by 2^16.
  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) prod_q[r][k] <= prod_full[r][k][63:16];
        tr_q[r] <= mat_q[12 + Rows[r]];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = ClipSumW'(prod_q[r][0]) + ClipSumW'(prod_q[r][1])
             + ClipSumW'(prod_q[r][2]) + ClipSumW'(tr_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      job_q.cx <= sum[0];
      job_q.cy <= sum[1];
      job_q.cw <= sum[2];
      job_q.in_front <= !(sum[2] < pws_pkg::WMinRaw);
    end
  end

  assign job_valid_o = s2_valid_q;
  assign job_o       = job_q;
  assign busy_o      = s1_valid_q || s2_valid_q;

endmodule

// ===== rtl/pws_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pws_back
// Divides x and y by w and maps the quotients to pixels, pipelined.
// ----------------------------------------------------------------------------
`include "perspective_world_to_screen_top_defines.svh"
module pws_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  input  pws_pkg::job_t                   job_i,
  input  logic [pws_pkg::CfgWidth-1:0]    width_i,
  input  logic [pws_pkg::CfgWidth-1:0]    height_i,
  input  logic                            stall_i,
  output logic                            res_valid_o,
  output pws_pkg::out_word_t              res_o
);

  localparam int unsigned N = pws_pkg::NumWidth;
  localparam int unsigned S = pws_pkg::DivSteps;
  localparam int unsigned WW = 49;

  // One restoring-division step per stage for both quotients.
  logic [S:0]          v_q;
  logic                f_q   [S+1];
  logic [N-1:0]        nx_q  [S+1];
  logic [N-1:0]        ny_q  [S+1];
  logic [WW:0]         rx_q  [S+1];
  logic [WW:0]         ry_q  [S+1];
  logic                sx_q  [S+1];
  logic                sy_q  [S+1];
  logic [WW-1:0]       d_q   [S+1];

  function automatic logic [N-1:0] mag_shift(input logic signed [49:0] v);
    logic [49:0] m;
    m = v[49] ? 50'(-v) : 50'(v);
    return {m, 16'd0};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (!stall_i) v_q <= {v_q[S-1:0], job_valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      f_q[0]  <= job_i.in_front;
      nx_q[0] <= mag_shift(job_i.cx);
      ny_q[0] <= mag_shift(job_i.cy);
      sx_q[0] <= job_i.cx[49];
      sy_q[0] <= job_i.cy[49];
      rx_q[0] <= '0;
      ry_q[0] <= '0;
      d_q[0]  <= job_i.cw[WW-1:0];
      for (int s = 0; s < S; s++) begin
        logic [WW+1:0] tx, ty;
        tx = {rx_q[s], nx_q[s][N-1]};
        ty = {ry_q[s], ny_q[s][N-1]};
        f_q[s+1] <= f_q[s];
        sx_q[s+1] <= sx_q[s];
        sy_q[s+1] <= sy_q[s];
        d_q[s+1] <= d_q[s];
        if (tx >= {2'b0, d_q[s]}) begin
          rx_q[s+1] <= (WW+1)'(tx - {2'b0, d_q[s]});
          nx_q[s+1] <= {nx_q[s][N-2:0], 1'b1};
        end else begin
          rx_q[s+1] <= tx[WW:0];
          nx_q[s+1] <= {nx_q[s][N-2:0], 1'b0};
        end
        if (ty >= {2'b0, d_q[s]}) begin
          ry_q[s+1] <= (WW+1)'(ty - {2'b0, d_q[s]});
          ny_q[s+1] <= {ny_q[s][N-2:0], 1'b1};
        end else begin
          ry_q[s+1] <= ty[WW:0];
          ny_q[s+1] <= {ny_q[s][N-2:0], 1'b0};
        end
      end
    end
  end

  // Saturate the signed quotient to 32 bits.
  function automatic logic signed [31:0] sat_q(input logic [N-1:0] q, input logic neg);
    logic signed [N:0] v;
    v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (v > $signed((N+1)'(32'sh7fffffff))) return 32'sh7fffffff;
    if (v < -$signed((N+1)'(33'h080000000))) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic              p_v_q, o_v_q;
  logic              p_f_q, o_f_q;
  logic signed [31:0] ndx_q, ndy_q;
  logic signed [50:0] px_q, py_q;
  logic [12:0]       hx_q, hy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (!stall_i) begin
      p_v_q <= v_q[S];
      o_v_q <= p_v_q;
    end
  end

  // Stage A: saturate quotients. Stage B: one multiply per axis and add.
  always_ff @(posedge clk_i) begin
    if (!stall_i) begin
      p_f_q <= f_q[S];
      ndx_q <= sat_q(nx_q[S], sx_q[S]);
      ndy_q <= sat_q(ny_q[S], sy_q[S]);
      hx_q  <= width_i[13:1];
      hy_q  <= height_i[13:1];
      px_q  <= 51'(ndx_q) * 51'($signed({1'b0, 14'(hx_q) + 14'd1}))
             + 51'($signed({1'b0, hx_q, 16'd0}));
      py_q  <= 51'(ndy_q) * 51'($signed({1'b0, 14'(hy_q) + 14'd1}))
             + 51'($signed({1'b0, hy_q, 16'd0}));
      o_f_q <= p_f_q;
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sh7fffffff) return 32'sh7fffffff;
    if (v < -51'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  assign res_valid_o    = o_v_q;
  assign res_o.in_front = o_f_q;
  assign res_o.pixel_x  = o_f_q ? sat32(px_q) : '0;
  assign res_o.pixel_y  = o_f_q ? sat32(py_q) : '0;

  `PWS_ASSERT_NEXT(a_hold, clk_i, rst_ni, stall_i, v_q == $past(v_q), "pipe moved in stall")
  `PWS_ASSERT_NEXT(a_out, clk_i, rst_ni, !stall_i && p_v_q, o_v_q, "result lost")
  `PWS_ASSERT_IMP(a_rej, clk_i, rst_ni, o_v_q && !res_o.in_front, res_o.pixel_x == '0, "reject")

endmodule

// ===== rtl/perspective_world_to_screen_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perspective_world_to_screen_top
// Projects world points through a 4x4 matrix to screen pixels.
// ----------------------------------------------------------------------------
// Channel   Handshake          Word
// input     push / full        in_word_i (load or transform)
// result    pop / empty        out_word_o
// config    cfg_valid_i/ready  cfg_index_i, cfg_data_i
// One word is accepted per cycle while full is low; a transform result passes
// through the front stages, the 66-step pipelined divider and the pixel stages.
// Reset clears the matrix and presets the viewport at once; no clearing pass.
// The pipeline advances only when its result slot is free; a 4-deep result
// queue decouples the output, and full rises when a finished result meets a
// full queue with no pop.
// ----------------------------------------------------------------------------
`include "perspective_world_to_screen_top_defines.svh"
module perspective_world_to_screen_top #(
  parameter int unsigned QDepth = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  pws_pkg::in_word_t               in_word_i,
  output logic                            empty,
  input  logic                            pop,
  output pws_pkg::out_word_t              out_word_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pws_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);

  localparam int unsigned AW = $clog2(QDepth);

  logic [pws_pkg::CfgWidth-1:0] width_q, height_q;
  logic job_v, res_v, stall, fbusy;
  pws_pkg::job_t     job;
  pws_pkg::out_word_t res;
  pws_pkg::out_word_t mem_q [QDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= pws_pkg::WidthReset;
      height_q <= pws_pkg::HeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pws_pkg::CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i[pws_pkg::CfgWidth-1:0];
        pws_pkg::CFG_SCREEN_HEIGHT: height_q <= cfg_data_i[pws_pkg::CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  // Stall the whole pipeline when a result would find no queue slot.
  assign stall = res_v && (cnt_q == (AW+1)'(QDepth)) && !pop;
  assign full  = stall;

  pws_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (push && !full),
    .in_word_i,
    .stall_i    (stall),
    .job_valid_o(job_v),
    .job_o      (job),
    .busy_o     (fbusy)
  );

  pws_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_v),
    .job_i      (job),
    .width_i    (width_q),
    .height_i   (height_q),
    .stall_i    (stall),
    .res_valid_o(res_v),
    .res_o      (res)
  );

  wire wr = res_v && !stall;
  wire rd = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (wr) wp_q <= (wp_q == AW'(QDepth-1)) ? '0 : wp_q + 1'b1;
      if (rd) rp_q <= (rp_q == AW'(QDepth-1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  assign empty      = (cnt_q == '0);
  assign out_word_o = mem_q[rp_q];

  `PWS_ASSERT_IMP(a_cnt, clk_i, rst_ni, 1'b1, cnt_q <= (AW+1)'(QDepth), "queue overflow")
  `PWS_ASSERT_NEXT(a_full, clk_i, rst_ni, stall, cnt_q == (AW+1)'(QDepth), "stall w/o full")
  `PWS_ASSERT_IMP(a_busy, clk_i, rst_ni, fbusy && stall, full, "front busy in stall")

endmodule
